@@ design/tspq_pkg.sv @@
//------------------------------------------------------------------------------
// tspq_pkg
// Shared types and codes for the three-class stable priority queue.
//------------------------------------------------------------------------------
`default_nettype none

package tspq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);

	// request codes
	localparam logic [2:0] REQ_INSERT    = 3'd0;
	localparam logic [2:0] REQ_SERVE     = 3'd1;
	localparam logic [2:0] REQ_SERVE_ALL = 3'd2;
	localparam logic [2:0] REQ_DISMISS   = 3'd3;
	localparam logic [2:0] REQ_VIEW      = 3'd4;

	// status codes
	localparam logic [2:0] STS_SERVED    = 3'd0;
	localparam logic [2:0] STS_LISTED    = 3'd1;
	localparam logic [2:0] STS_EMPTY     = 3'd2;
	localparam logic [2:0] STS_INSERTED  = 3'd3;
	localparam logic [2:0] STS_FULL      = 3'd4;
	localparam logic [2:0] STS_DISMISSED = 3'd5;

	localparam logic [1:0] CLS_REGULAR   = 2'd0;
	localparam logic [1:0] CLS_INVALID   = 2'd3;

	typedef struct packed {
		logic [15:0] id;
		logic [7:0]  age;
		logic [1:0]  cls;
	} entry_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_POP,
		OP_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		entry_t           ins;
		logic [CNT_W-1:0] cnt;
	} cell_ctrl_t;

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} state_t;

endpackage

`default_nettype wire

@@ design/tspq_cell.sv @@
//------------------------------------------------------------------------------
// tspq_cell
// One slot of the queue chain: holds its entry, or takes a new one from the new
// entry, its left neighbor, its right neighbor or the head.
//------------------------------------------------------------------------------
`default_nettype none

module tspq_cell
	import tspq_pkg::*;
(
	input  wire logic             clk,
	input  wire cell_ctrl_t       ctrl,
	input  wire logic [IDX_W-1:0] index,
	input  wire logic             left_ge,
	input  wire entry_t           left_ent,
	input  wire entry_t           right_ent,
	input  wire entry_t           head,
	output entry_t                ent,
	output logic                  ge
);

	entry_t ent_q;
	entry_t ent_nxt;
	logic   occupied;
	logic   at_tail;

	assign ent      = ent_q;
	assign occupied = {1'b0, index} < ctrl.cnt;
	assign at_tail  = {1'b0, index} == (ctrl.cnt - CNT_W'(1));
	assign ge       = occupied && (ent_q.cls >= ctrl.ins.cls);

	always_comb begin
		ent_nxt = ent_q;
		case (ctrl.op)
			OP_INSERT: begin
				if (!ge) begin
					ent_nxt = left_ge ? ctrl.ins : left_ent;
				end
			end
			OP_POP:    ent_nxt = right_ent;
			OP_ROTATE: ent_nxt = at_tail ? head : right_ent;
			default:   ent_nxt = ent_q;
		endcase
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_nxt;
	end

endmodule

`default_nettype wire

@@ design/three_level_stable_priority_queue.sv @@
//------------------------------------------------------------------------------
// three_level_stable_priority_queue
// Bounded priority queue with three classes, first in first out within a
// class, built as a chain of entry cells with a small sequencer.
//
//  channel   handshake          payload
//  request   start / busy       req_type guest_id guest_age guest_class
//  result    valid (strobe)     out_id out_age out_class status last
//
// insert, serve one, dismiss, and serve all or view on an empty queue give one
// result the cycle after acceptance; unused request codes give no result.
// serve all and view over n entries keep busy high while draining; the chain
// rotates one slot per cycle and the head is emitted each cycle.
// reset empties the queue; cell contents are not reset.
// results cannot be stalled.
//------------------------------------------------------------------------------
`default_nettype none

module three_level_stable_priority_queue
	import tspq_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  req_type,
	input  wire logic [15:0] guest_id,
	input  wire logic [7:0]  guest_age,
	input  wire logic [1:0]  guest_class,
	output logic             valid,
	output logic [15:0]      out_id,
	output logic [7:0]       out_age,
	output logic [1:0]       out_class,
	output logic [2:0]       status,
	output logic             last
);

	state_t           state_q, state_nxt;
	logic [CNT_W-1:0] cnt_q, cnt_nxt;
	logic [CNT_W-1:0] rem_q, rem_nxt;
	logic             serve_all_q, serve_all_nxt;

	logic             accept;
	logic             empty;
	logic             full;
	cell_ctrl_t       ctrl;
	entry_t           ins;
	entry_t           head;

	logic             emit;
	entry_t           emit_ent;
	logic [2:0]       emit_sts;
	logic             emit_last;

	entry_t           valid_ent_q;
	logic             valid_q;
	logic [2:0]       status_q;
	logic             last_q;

	entry_t           ent [QUEUE_DEPTH];
	logic             ge  [QUEUE_DEPTH];

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign empty  = (cnt_q == '0);
	assign full   = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign head   = ent[0];

	assign ins.id  = guest_id;
	assign ins.age = guest_age;
	assign ins.cls = (guest_class == CLS_INVALID) ? CLS_REGULAR : guest_class;

	// cell chain
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic   l_ge;
		entry_t l_ent;
		entry_t r_ent;

		if (i == 0) begin : g_first
			assign l_ge  = 1'b1;
			assign l_ent = ins;
		end else begin : g_mid
			assign l_ge  = ge[i-1];
			assign l_ent = ent[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign r_ent = '0;
		end else begin : g_inner
			assign r_ent = ent[i+1];
		end

		tspq_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.index     (IDX_W'(i)),
			.left_ge   (l_ge),
			.left_ent  (l_ent),
			.right_ent (r_ent),
			.head      (head),
			.ent       (ent[i]),
			.ge        (ge[i])
		);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && !empty && (req_type inside {REQ_SERVE_ALL, REQ_VIEW})) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (rem_q == CNT_W'(1)) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs and cell control
	always_comb begin
		ctrl.op       = OP_HOLD;
		ctrl.ins      = ins;
		ctrl.cnt      = cnt_q;
		cnt_nxt       = cnt_q;
		rem_nxt       = rem_q;
		serve_all_nxt = serve_all_q;
		emit          = 1'b0;
		emit_ent      = '0;
		emit_sts      = STS_EMPTY;
		emit_last     = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req_type)
						REQ_INSERT: begin
							emit = 1'b1;
							if (full) begin
								emit_sts = STS_FULL;
							end else begin
								ctrl.op  = OP_INSERT;
								cnt_nxt  = cnt_q + CNT_W'(1);
								emit_ent = ins;
								emit_sts = STS_INSERTED;
							end
						end
						REQ_SERVE: begin
							emit = 1'b1;
							if (!empty) begin
								ctrl.op  = OP_POP;
								cnt_nxt  = cnt_q - CNT_W'(1);
								emit_ent = head;
								emit_sts = STS_SERVED;
							end
						end
						REQ_DISMISS: begin
							emit = 1'b1;
							if (!empty) begin
								cnt_nxt  = '0;
								emit_sts = STS_DISMISSED;
							end
						end
						REQ_SERVE_ALL, REQ_VIEW: begin
							emit          = empty;
							rem_nxt       = cnt_q;
							serve_all_nxt = (req_type == REQ_SERVE_ALL);
						end
						default: emit = 1'b0;
					endcase
				end
			end
			ST_DRAIN: begin
				ctrl.op   = OP_ROTATE;
				emit      = 1'b1;
				emit_ent  = head;
				emit_sts  = serve_all_q ? STS_SERVED : STS_LISTED;
				emit_last = (rem_q == CNT_W'(1));
				rem_nxt   = rem_q - CNT_W'(1);
				if (emit_last && serve_all_q) begin
					cnt_nxt = '0;
				end
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rem_q       <= '0;
			serve_all_q <= 1'b0;
			valid_q     <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			cnt_q       <= cnt_nxt;
			rem_q       <= rem_nxt;
			serve_all_q <= serve_all_nxt;
			valid_q     <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			valid_ent_q <= emit_ent;
			status_q    <= emit_sts;
			last_q      <= emit_last;
		end
	end

	assign valid     = valid_q;
	assign out_id    = valid_ent_q.id;
	assign out_age   = valid_ent_q.age;
	assign out_class = valid_ent_q.cls;
	assign status    = status_q;
	assign last      = last_q;

endmodule

`default_nettype wire

@@ tb/guest_queue_checker.sv @@
//------------------------------------------------------------------------------
// guest_queue_checker
// Watches the request and result channels of the three-class stable priority
// queue. A queue model of its own predicts the results of every accepted
// transaction; each result strobe is compared field by field with the oldest
// prediction. Reports the failure count and the number of results still due.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module guest_queue_checker
	import tspq_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [2:0]  req_type,
	input  wire logic [15:0] guest_id,
	input  wire logic [7:0]  guest_age,
	input  wire logic [1:0]  guest_class,
	input  wire logic        valid,
	input  wire logic [15:0] out_id,
	input  wire logic [7:0]  out_age,
	input  wire logic [1:0]  out_class,
	input  wire logic [2:0]  status,
	input  wire logic        last,
	output int               failures,
	output int               results_due
);

	localparam int SHOWN_FAILURES = 10;

	typedef struct packed {
		entry_t     guest;
		logic [2:0] sts;
		logic       fin;
	} guest_result_t;

	entry_t        guest_line[QUEUE_DEPTH];
	int            guest_count;
	guest_result_t due_results[$];

	task automatic add_due(input entry_t guest, input logic [2:0] sts, input logic fin);
		guest_result_t r;
		r.guest = guest;
		r.sts   = sts;
		r.fin   = fin;
		due_results.push_back(r);
	endtask

	task automatic predict_guest_request(input logic [2:0] req, input entry_t arrival);
		entry_t blank;
		int     pos;
		blank = '0;
		if (req > REQ_VIEW) begin
			return;
		end
		if (req == REQ_INSERT) begin
			if (arrival.cls == CLS_INVALID)
				arrival.cls = CLS_REGULAR;
			if (guest_count >= QUEUE_DEPTH) begin
				add_due(blank, STS_FULL, 1'b1);
				return;
			end
			pos = 0;
			while (pos < guest_count && guest_line[pos].cls >= arrival.cls)
				pos++;
			for (int i = guest_count; i > pos; i--)
				guest_line[i] = guest_line[i-1];
			guest_line[pos] = arrival;
			guest_count++;
			add_due(arrival, STS_INSERTED, 1'b1);
			return;
		end
		if (guest_count == 0) begin
			add_due(blank, STS_EMPTY, 1'b1);
			return;
		end
		case (req)
			REQ_SERVE: begin
				add_due(guest_line[0], STS_SERVED, 1'b1);
				for (int i = 1; i < guest_count; i++)
					guest_line[i-1] = guest_line[i];
				guest_count--;
			end
			REQ_DISMISS: begin
				guest_count = 0;
				add_due(blank, STS_DISMISSED, 1'b1);
			end
			default: begin
				for (int i = 0; i < guest_count; i++)
					add_due(guest_line[i], (req == REQ_SERVE_ALL) ? STS_SERVED : STS_LISTED,
						i + 1 == guest_count);
				if (req == REQ_SERVE_ALL)
					guest_count = 0;
			end
		endcase
	endtask

	task automatic check_result();
		guest_result_t want;
		if (due_results.size() == 0) begin
			failures++;
			if (failures <= SHOWN_FAILURES)
				$display("%0t: unexpected result id=%h age=%h class=%0d status=%0d last=%b",
					$realtime, out_id, out_age, out_class, status, last);
			return;
		end
		want = due_results.pop_front();
		if (out_id !== want.guest.id || out_age !== want.guest.age ||
				out_class !== want.guest.cls || status !== want.sts || last !== want.fin) begin
			failures++;
			if (failures <= SHOWN_FAILURES)
				$display("%0t: result mismatch, expected id=%h age=%h class=%0d status=%0d last=%b, got id=%h age=%h class=%0d status=%0d last=%b",
					$realtime, want.guest.id, want.guest.age, want.guest.cls, want.sts,
					want.fin, out_id, out_age, out_class, status, last);
		end
	endtask

	initial begin
		failures    = 0;
		results_due = 0;
		guest_count = 0;
	end

	// results first, so a transaction accepted on this edge cannot claim them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guest_count = 0;
			due_results.delete();
		end else begin
			if (valid)
				check_result();
			if (start && !busy)
				predict_guest_request(req_type, '{id: guest_id, age: guest_age, cls: guest_class});
		end
		results_due = due_results.size();
	end

endmodule

@@ tb/testbench.sv @@
//------------------------------------------------------------------------------
// testbench
// Drives the three-class stable priority queue with a directed sequence (empty
// queue requests, a fill to capacity, a rejected insert, listing, serving,
// dismissal and unused request codes) followed by random requests with random
// sender gaps and a full drain pause halfway. The checker predicts and compares.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import tspq_pkg::*;

	localparam logic [2:0] REQ_FIRST_UNUSED = 3'd5;
	localparam logic [2:0] REQ_LAST_UNUSED  = 3'd7;
	localparam int         RANDOM_ITEMS     = 90;
	localparam int         STALL_LIMIT      = 2000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  req_type;
	logic [15:0] guest_id;
	logic [7:0]  guest_age;
	logic [1:0]  guest_class;
	logic        valid;
	logic [15:0] out_id;
	logic [7:0]  out_age;
	logic [1:0]  out_class;
	logic [2:0]  status;
	logic        last;
	int          failures;
	int          results_due;
	int          stalled_cycles;

	three_level_stable_priority_queue DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .guest_id(guest_id), .guest_age(guest_age),
		.guest_class(guest_class), .valid(valid), .out_id(out_id), .out_age(out_age),
		.out_class(out_class), .status(status), .last(last)
	);

	guest_queue_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .guest_id(guest_id), .guest_age(guest_age),
		.guest_class(guest_class), .valid(valid), .out_id(out_id), .out_age(out_age),
		.out_class(out_class), .status(status), .last(last),
		.failures(failures), .results_due(results_due)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// watchdog on cycles with no request transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stalled_cycles <= 0;
		end else if (start && !busy) begin
			stalled_cycles <= 0;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
			if (stalled_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic send_request(input logic [2:0] req, input logic [15:0] id,
			input logic [7:0] age, input logic [1:0] cls, input bit may_idle);
		if (may_idle && $urandom_range(0, 99) < 25) begin
			@(negedge clk);
			start       <= 1'b0;
			guest_id    <= 16'($urandom);
			guest_age   <= 8'($urandom);
			repeat ($urandom_range(0, 2)) @(negedge clk);
		end
		@(negedge clk);
		start       <= 1'b1;
		req_type    <= req;
		guest_id    <= id;
		guest_age   <= age;
		guest_class <= cls;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (results_due != 0) @(negedge clk);
	endtask

	initial begin
		logic [2:0] req;
		int         pick;
		int         counted;
		arst_n      = 1'b0;
		start       = 1'b0;
		req_type    = REQ_INSERT;
		guest_id    = '0;
		guest_age   = '0;
		guest_class = CLS_REGULAR;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty queue
		send_request(REQ_SERVE, 16'($urandom), 8'($urandom), 2'($urandom), 1'b1);
		send_request(REQ_VIEW, 16'($urandom), 8'($urandom), 2'($urandom), 1'b1);
		send_request(REQ_SERVE_ALL, 16'($urandom), 8'($urandom), 2'($urandom), 1'b1);
		send_request(REQ_DISMISS, 16'($urandom), 8'($urandom), 2'($urandom), 1'b1);
		// fill to capacity with every class code, then overflow
		for (int i = 0; i < QUEUE_DEPTH; i++)
			send_request(REQ_INSERT,
				(i == 0) ? 16'hFFFF : (i == 1) ? 16'h0000 : 16'($urandom),
				(i == 0) ? 8'hFF : (i == 1) ? 8'h00 : 8'($urandom),
				2'(i), 1'b1);
		send_request(REQ_INSERT, 16'hFFFF, 8'hFF, CLS_INVALID, 1'b1);
		send_request(REQ_VIEW, 16'($urandom), 8'($urandom), 2'($urandom), 1'b1);
		send_request(REQ_SERVE, 16'($urandom), 8'($urandom), 2'($urandom), 1'b1);
		send_request(REQ_SERVE_ALL, 16'($urandom), 8'($urandom), 2'($urandom), 1'b1);
		send_request(REQ_INSERT, 16'($urandom), 8'($urandom), 2'd2, 1'b1);
		send_request(REQ_DISMISS, 16'($urandom), 8'($urandom), 2'($urandom), 1'b1);
		send_request(REQ_FIRST_UNUSED, 16'($urandom), 8'($urandom), 2'($urandom), 1'b1);
		send_request(REQ_LAST_UNUSED, 16'($urandom), 8'($urandom), 2'($urandom), 1'b1);

		// random traffic, insert heavy first so the queue reaches full
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (counted < RANDOM_ITEMS / 2)
				req = (pick < 60) ? REQ_INSERT : (pick < 72) ? REQ_SERVE :
					(pick < 78) ? REQ_SERVE_ALL : (pick < 82) ? REQ_DISMISS :
					(pick < 92) ? REQ_VIEW : 3'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_UNUSED));
			else
				req = (pick < 40) ? REQ_INSERT : (pick < 62) ? REQ_SERVE :
					(pick < 72) ? REQ_SERVE_ALL : (pick < 77) ? REQ_DISMISS :
					(pick < 90) ? REQ_VIEW : 3'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_UNUSED));
			if (counted == RANDOM_ITEMS / 2)
				drain_results();
			send_request(req, 16'($urandom), 8'($urandom), 2'($urandom_range(0, 3)),
				!(counted >= 30 && counted < 60));
			if (req <= REQ_VIEW)
				counted++;
		end

		drain_results();
		repeat (20) @(negedge clk);
		if (failures == 0 && results_due == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ filelist.f @@
design/tspq_pkg.sv
design/tspq_cell.sv
design/three_level_stable_priority_queue.sv
tb/guest_queue_checker.sv
tb/testbench.sv
